// ===== sv/odpm_pkg.sv =====
// shared types, constants and helper functions of the ordered dither palette mapper
package odpm_pkg;

  localparam int MATRIX_SIZE_DEF = 8;
  localparam int CFG_AW          = 5;
  localparam int CFG_DW          = 32;
  localparam int NUM_LANES       = 3;

  typedef enum logic [2:0] {
    REG_GRAY_MODE    = 3'd0,
    REG_SHADES_RED   = 3'd1,
    REG_SHADES_GREEN = 3'd2,
    REG_SHADES_BLUE  = 3'd3,
    REG_GRAY_LEVELS  = 3'd4
  } odpm_reg_t;

  localparam logic       GRAY_MODE_RST    = 1'b0;
  localparam logic [8:0] SHADES_RED_RST   = 9'd8;
  localparam logic [8:0] SHADES_GREEN_RST = 9'd8;
  localparam logic [8:0] SHADES_BLUE_RST  = 9'd4;
  localparam logic [8:0] GRAY_LEVELS_RST  = 9'd256;

  // ceil(2^16 / 10), exact floor for sums up to 2550
  localparam logic [12:0] LUMA_RECIP = 13'd6554;

  // per-stage load strobes handed to each shade lane
  typedef struct packed {
    logic ld_t;
    logic ld_pick;
  } odpm_adv_t;

  // shade count minus one, count clamped to 2..256
  function automatic logic [7:0] shades_minus_one(input logic [8:0] n);
    logic [7:0] res;
    if (n <= 9'd2) begin
      res = 8'd1;
    end else if (n >= 9'd256) begin
      res = 8'd255;
    end else begin
      res = n[7:0] - 8'd1;
    end
    return res;
  endfunction

  // low byte of the clamped shade count
  function automatic logic [7:0] shade_weight(input logic [8:0] n);
    logic [7:0] res;
    if (n < 9'd2) begin
      res = 8'd2;
    end else if (n >= 9'd256) begin
      res = 8'd0;
    end else begin
      res = n[7:0];
    end
    return res;
  endfunction

endpackage

// ===== sv/odpm_shade_lane.sv =====
// one colour channel: shade split, weighting and threshold compare
module odpm_shade_lane import odpm_pkg::*; #(
  parameter int MAT_BITS = 3
) (
  input  logic                    clk,
  input  odpm_adv_t               adv,
  input  logic [7:0]              v_i,
  input  logic [7:0]              nm1_i,
  input  logic [7:0]              w_i,
  input  logic [2*MAT_BITS-1:0]   m_i,
  output logic [7:0]              pick_o
);

  localparam int M_W     = 2 * MAT_BITS;
  localparam int IDX_W   = M_W + 1;
  localparam int THR_MUL = (1 << M_W) + 1;
  localparam int PW      = 8 + IDX_W;

  logic [15:0]      t_r, t_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [7:0]       lob_r, lob_nxt;
  logic [7:0]       hib_r, hib_nxt;
  logic [7:0]       lo;
  logic [PW-1:0]    frac_prod;
  logic [15:0]      lob_prod;
  logic [IDX_W-1:0] m_ext;
  logic             take_hi;

  always_comb begin
    t_nxt     = {8'd0, v_i} * {8'd0, nm1_i};
    lo        = t_r[15:8];
    frac_prod = PW'(t_r[7:0]) * PW'(THR_MUL);
    idx_nxt   = frac_prod[PW-1:8];
    lob_prod  = {8'd0, lo} * {8'd0, w_i};
    lob_nxt   = lob_prod[7:0];
    // (lo + 1) * w mod 256
    hib_nxt   = lob_prod[7:0] + w_i;
  end

  always_ff @(posedge clk) begin
    if (adv.ld_t) begin
      t_r <= t_nxt;
    end
    if (adv.ld_pick) begin
      idx_r <= idx_nxt;
      lob_r <= lob_nxt;
      hib_r <= hib_nxt;
    end
  end

  // m*2^16 < idx*2^16 + hib*2^8 + lob, the low part being below 2^16
  always_comb begin
    m_ext   = IDX_W'(m_i);
    take_hi = (m_ext < idx_r) || ((m_ext == idx_r) && ((hib_r | lob_r) != 8'd0));
    pick_o  = take_hi ? hib_r : lob_r;
  end

endmodule

// ===== sv/ordered_dither_palette_map_unit.sv =====
// top level of the ordered dither palette mapper: config registers and pixel pipeline
//
// maps one rgb pixel per transfer to an 8-bit palette index by bayer ordered dithering
// input channel: in_valid/in_ready with in_red, in_green, in_blue, in_row, in_col_phase
// result channel: out_valid/out_ready with out_palette_index, one result per pixel
// config: apb-style write/read port, registers at byte offsets 0,4,8,12,16
//   (gray_mode, shades_red, shades_green, shades_blue, gray levels); pready is
//   tied high; write registers only while no pixel is in flight
// latency: out_valid rises four cycles after the input transfer, so the result can
//   transfer at the fifth edge; set by the five register stages (input/weighted sum,
//   luma scale, shade product, shade split, output)
// throughput: one pixel per cycle; every stage carries its own valid bit
// receiver stall: out_valid holds with a stable index; earlier stages keep filling
//   bubbles and in_ready drops only once all five stages hold a pixel
// reset (rst_n low, synchronous): pipeline emptied, registers back to their
//   defaults (colour mode, 8/8/4 cube, 256 gray levels)
module ordered_dither_palette_map_unit import odpm_pkg::*; #(
  parameter int MATRIX_SIZE = MATRIX_SIZE_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [7:0]        in_red,
  input  logic [7:0]        in_green,
  input  logic [7:0]        in_blue,
  input  logic [2:0]        in_row,
  input  logic [2:0]        in_col_phase,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [7:0]        out_palette_index
);

  localparam int MAT_BITS = (MATRIX_SIZE >= 8) ? 3 : 2;
  localparam int M_W      = 2 * MAT_BITS;
  localparam int NSTG     = 5;

  // configuration registers
  logic       gray_mode_r;
  logic [8:0] shades_red_r, shades_green_r, shades_blue_r, gray_levels_r;
  logic       cfg_wr;
  odpm_reg_t  cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite;
  assign cfg_sel = odpm_reg_t'(paddr[CFG_AW-1:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gray_mode_r    <= GRAY_MODE_RST;
      shades_red_r   <= SHADES_RED_RST;
      shades_green_r <= SHADES_GREEN_RST;
      shades_blue_r  <= SHADES_BLUE_RST;
      gray_levels_r  <= GRAY_LEVELS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_sel)
        REG_GRAY_MODE:    gray_mode_r    <= pwdata[0];
        REG_SHADES_RED:   shades_red_r   <= pwdata[8:0];
        REG_SHADES_GREEN: shades_green_r <= pwdata[8:0];
        REG_SHADES_BLUE:  shades_blue_r  <= pwdata[8:0];
        REG_GRAY_LEVELS:  gray_levels_r  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (cfg_sel)
      REG_GRAY_MODE:    prdata = CFG_DW'(gray_mode_r);
      REG_SHADES_RED:   prdata = CFG_DW'(shades_red_r);
      REG_SHADES_GREEN: prdata = CFG_DW'(shades_green_r);
      REG_SHADES_BLUE:  prdata = CFG_DW'(shades_blue_r);
      REG_GRAY_LEVELS:  prdata = CFG_DW'(gray_levels_r);
      default:          prdata = '0;
    endcase
  end

  // per-lane shade parameters, registered off the config so no multiply chains
  logic [7:0]  lane_nm1_r [NUM_LANES];
  logic [7:0]  lane_nm1_nxt [NUM_LANES];
  logic [7:0]  lane_w_r [NUM_LANES];
  logic [7:0]  lane_w_nxt [NUM_LANES];
  logic [15:0] red_w_prod;

  always_comb begin
    red_w_prod      = {8'd0, shade_weight(shades_green_r)} * {8'd0, shade_weight(shades_blue_r)};
    lane_nm1_nxt[0] = gray_mode_r ? shades_minus_one(gray_levels_r)
                                  : shades_minus_one(shades_red_r);
    lane_w_nxt[0]   = gray_mode_r ? 8'd1 : red_w_prod[7:0];
    lane_nm1_nxt[1] = shades_minus_one(shades_green_r);
    lane_w_nxt[1]   = shade_weight(shades_blue_r);
    lane_nm1_nxt[2] = shades_minus_one(shades_blue_r);
    lane_w_nxt[2]   = 8'd1;
  end

  always_ff @(posedge clk) begin
    for (int i = 0; i < NUM_LANES; i++) begin
      lane_nm1_r[i] <= lane_nm1_nxt[i];
      lane_w_r[i]   <= lane_w_nxt[i];
    end
  end

  // pipeline flow control
  logic [NSTG:1] vld_r, vld_nxt, rdy;

  always_comb begin
    rdy[NSTG] = !vld_r[NSTG] || out_ready;
    for (int k = NSTG - 1; k >= 1; k--) begin
      rdy[k] = !vld_r[k] || rdy[k+1];
    end
    vld_nxt[1] = rdy[1] ? in_valid : vld_r[1];
    for (int k = 2; k <= NSTG; k++) begin
      vld_nxt[k] = rdy[k] ? vld_r[k-1] : vld_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= vld_nxt;
    end
  end

  assign in_ready  = rdy[1];
  assign out_valid = vld_r[NSTG];

  // stage 1: threshold entry and luma weighted sum
  logic [MAT_BITS-1:0] bx, by;
  logic [M_W-1:0]      m_nxt;
  logic [11:0]         wsum_nxt;
  logic [7:0]          red1_r, green1_r, blue1_r;
  logic [11:0]         wsum1_r;
  logic [M_W-1:0]      m1_r, m2_r, m3_r, m4_r;

  always_comb begin
    bx    = in_row[MAT_BITS-1:0] ^ in_col_phase[MAT_BITS-1:0];
    by    = in_row[MAT_BITS-1:0];
    m_nxt = '0;
    // bit-interleave of (row ^ col) and row, reversed
    for (int k = 0; k < MAT_BITS; k++) begin
      m_nxt[2*(MAT_BITS-1-k)+1] = bx[k];
      m_nxt[2*(MAT_BITS-1-k)]   = by[k];
    end
    wsum_nxt = ({4'd0, in_red} << 1) + {4'd0, in_red}
             + ({4'd0, in_green} << 2) + ({4'd0, in_green} << 1)
             + {4'd0, in_blue};
  end

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      red1_r   <= in_red;
      green1_r <= in_green;
      blue1_r  <= in_blue;
      wsum1_r  <= wsum_nxt;
      m1_r     <= m_nxt;
    end
  end

  // stage 2: luma = wsum / 10 by reciprocal, lane value select
  logic [24:0] luma_prod;
  logic [7:0]  lane_v2_r [NUM_LANES];

  assign luma_prod = 25'(wsum1_r) * 25'(LUMA_RECIP);

  always_ff @(posedge clk) begin
    if (rdy[2]) begin
      lane_v2_r[0] <= gray_mode_r ? luma_prod[23:16] : red1_r;
      lane_v2_r[1] <= green1_r;
      lane_v2_r[2] <= blue1_r;
      m2_r         <= m1_r;
    end
  end

  // stages 3 and 4 live in the lanes; carry the threshold alongside
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      m3_r <= m2_r;
    end
    if (rdy[4]) begin
      m4_r <= m3_r;
    end
  end

  odpm_adv_t  adv;
  logic [7:0] pick [NUM_LANES];

  assign adv.ld_t    = rdy[3];
  assign adv.ld_pick = rdy[4];

  for (genvar i = 0; i < NUM_LANES; i++) begin : g_lane
    odpm_shade_lane #(
      .MAT_BITS (MAT_BITS)
    ) u_lane (
      .clk    (clk),
      .adv    (adv),
      .v_i    (lane_v2_r[i]),
      .nm1_i  (lane_nm1_r[i]),
      .w_i    (lane_w_r[i]),
      .m_i    (m4_r),
      .pick_o (pick[i])
    );
  end

  // stage 5: output register
  logic [7:0] out_idx_r, out_idx_nxt;

  assign out_idx_nxt = gray_mode_r ? pick[0] : (pick[0] + pick[1] + pick[2]);

  always_ff @(posedge clk) begin
    if (rdy[NSTG]) begin
      out_idx_r <= out_idx_nxt;
    end
  end

  assign out_palette_index = out_idx_r;

  a_empty_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r == '0) |-> in_ready)
    else $error("empty pipeline refuses input");

  a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    ((&vld_r) && !out_ready) |-> !in_ready)
    else $error("full stalled pipeline takes input");

  a_stage4_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (vld_r[4] && !rdy[5]) |=> (vld_r[4] && $stable(m4_r)))
    else $error("stalled shade stage lost its pixel");

endmodule
